FILE: rtl/core/pfc_pkg.sv
package pfc_pkg;

  typedef enum logic [2:0] {
    FMT_UNORM8  = 3'd0,
    FMT_UNORM16 = 3'd1,
    FMT_HALF    = 3'd2,
    FMT_SINGLE  = 3'd3,
    FMT_DOUBLE  = 3'd4
  } pfc_fmt_e;

  typedef enum logic {
    OP_UNPACK = 1'b0,
    OP_PACK   = 1'b1
  } pfc_op_e;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_SWAP   = 1'b1;

  typedef struct packed {
    logic [2:0] fmt;
    logic       swap;
  } pfc_cfg_t;

endpackage

FILE: rtl/core/pfc_convert.sv
module pfc_convert (
  input  pfc_pkg::pfc_cfg_t cfg_i,
  input  logic              operation_i,
  input  logic [63:0]       stored_word_i,
  input  logic [31:0]       float_in_i,
  output logic [31:0]       float_out_o,
  output logic [63:0]       stored_out_o
);
  import pfc_pkg::*;

  function automatic logic [63:0] rne_shift(input logic [63:0] v, input logic [5:0] sh);
    logic [63:0] q;
    logic        g;
    logic        st;
    q  = v >> sh;
    g  = v[sh - 6'd1];
    st = |(v & ((64'd1 << (sh - 6'd1)) - 64'd1));
    if (g && (st || q[0])) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  function automatic logic [5:0] top_one(input logic [39:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 40; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [63:0] swap16(input logic [63:0] v);
    return {48'd0, v[7:0], v[15:8]};
  endfunction

  function automatic logic [63:0] swap32(input logic [63:0] v);
    return {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24], v[39:32], v[47:40], v[55:48], v[63:56]};
  endfunction

  function automatic logic [31:0] unorm_unpack(input logic [15:0] v, input logic is16);
    logic [63:0] pat;
    logic [63:0] shd;
    logic [5:0]  p;
    logic [4:0]  lz;
    logic [31:0] r;
    pat = is16 ? {4{v}} : {8{v[7:0]}};
    p   = top_one({24'd0, v});
    lz  = is16 ? 5'(6'd15 - p) : 5'(6'd7 - p);
    shd = pat << lz;
    r   = {1'b0, 8'(8'd126 - {3'd0, lz}), shd[62:40]} + {31'd0, shd[39]};
    if (is16 ? (v == 16'd0) : (v[7:0] == 8'd0)) begin
      r = 32'd0;
    end
    return r;
  endfunction

  function automatic logic [15:0] unorm_pack(input logic [31:0] f, input logic is16);
    logic [7:0]  e;
    logic [7:0]  eb;
    logic [23:0] mm;
    logic [39:0] pp;
    logic [5:0]  l;
    logic [5:0]  d;
    logic [63:0] rr;
    logic [7:0]  a;
    logic [63:0] ff;
    logic [63:0] fr;
    logic [15:0] scale;
    logic [15:0] res;
    e     = f[30:23];
    scale = is16 ? 16'hFFFF : 16'h00FF;
    eb    = (e == 8'd0) ? 8'd1 : e;
    mm    = {e != 8'd0, f[22:0]};
    pp    = is16 ? (({16'd0, mm} << 16) - {16'd0, mm}) : (({16'd0, mm} << 8) - {16'd0, mm});
    l     = top_one(pp);
    if (l > 6'd23) begin
      d  = l - 6'd23;
      rr = rne_shift({24'd0, pp}, d);
    end else begin
      d  = 6'd0;
      rr = {24'd0, pp};
    end
    a  = 8'd149 - {2'd0, d} - eb;
    ff = rr >> a;
    fr = ff + 64'd1;
    res = fr[16:1];
    if (rr == 64'h0000_0000_00FF_FFFF && a == 8'd24) begin
      res = 16'd1;
    end
    if (e == 8'hFF && f[22:0] != 23'd0) begin
      res = scale;
    end else if (f[31]) begin
      res = 16'd0;
    end else if (e >= 8'd127) begin
      res = scale;
    end else if (f[30:0] == 31'd0) begin
      res = 16'd0;
    end
    return res;
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [5:0]  p;
    logic [3:0]  sh;
    logic [9:0]  mant;
    logic [7:0]  be;
    logic [31:0] r;
    e  = h[14:10];
    m  = h[9:0];
    p  = top_one({30'd0, m});
    sh = 4'(6'd10 - p);
    if (e == 5'h1F) begin
      r = (m != 10'd0) ? {h[15], 8'hFF, 1'b1, m[8:0], 13'd0}
                       : {h[15], 8'hFF, 23'd0};
    end else if (e == 5'd0 && m == 10'd0) begin
      r = {h[15], 31'd0};
    end else if (e == 5'd0) begin
      mant = 10'(m << sh);
      be   = 8'd113 - {4'd0, sh};
      r    = {h[15], be, mant, 13'd0};
    end else begin
      be = {3'd0, e} + 8'd112;
      r  = {h[15], be, m, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] f);
    logic [7:0]        e;
    logic [22:0]       m;
    logic signed [9:0] eb;
    logic [63:0]       q;
    logic [14:0]       mag;
    e  = f[30:23];
    m  = f[22:0];
    eb = $signed({2'd0, e}) - 10'sd112;
    q  = 64'd0;
    if (e == 8'hFF) begin
      mag = (m != 23'd0) ? (15'h7E00 | {5'd0, m[22:13]}) : 15'h7C00;
    end else if (e == 8'd0) begin
      mag = 15'd0;
    end else if (eb >= 10'sd31) begin
      mag = 15'h7C00;
    end else if (eb >= 10'sd1) begin
      q   = rne_shift({40'd0, 1'b1, m}, 6'd13);
      mag = 15'({eb[4:0] - 5'd1, 10'd0} + q[14:0]);
    end else if (eb < -10'sd48) begin
      mag = 15'd0;
    end else begin
      q   = rne_shift({40'd0, 1'b1, m}, 6'(10'sd14 - eb));
      mag = q[14:0];
    end
    return {f[31], mag};
  endfunction

  function automatic logic [63:0] single_to_double(input logic [31:0] f);
    logic [7:0]  e;
    logic [22:0] m;
    logic [5:0]  p;
    logic [4:0]  sh;
    logic [22:0] mant;
    logic [10:0] be;
    logic [63:0] r;
    e  = f[30:23];
    m  = f[22:0];
    p  = top_one({17'd0, m});
    sh = 5'(6'd23 - p);
    if (e == 8'hFF) begin
      r = (m != 23'd0) ? {f[31], 63'h7FF8000000000000 | {11'd0, 23'd0, m, 6'd0} << 23}
                       : {f[31], 63'h7FF0000000000000};
      if (m != 23'd0) begin
        r = {f[31], 11'h7FF, 1'b1, m[21:0], 29'd0} | {1'd0, 11'd0, m[22], 51'd0};
      end
    end else if (e == 8'd0 && m == 23'd0) begin
      r = {f[31], 63'd0};
    end else if (e == 8'd0) begin
      mant = 23'(m << sh);
      be   = 11'd897 - {6'd0, sh};
      r    = {f[31], be, mant, 29'd0};
    end else begin
      be = {3'd0, e} + 11'd896;
      r  = {f[31], be, m, 29'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] double_to_single(input logic [63:0] dv);
    logic [10:0]        e;
    logic [51:0]        m;
    logic signed [12:0] eb;
    logic [63:0]        q;
    logic [30:0]        mag;
    e  = dv[62:52];
    m  = dv[51:0];
    eb = $signed({2'd0, e}) - 13'sd896;
    q  = 64'd0;
    if (e == 11'h7FF) begin
      mag = (m != 52'd0) ? (31'h7FC00000 | {8'd0, m[51:29]}) : 31'h7F800000;
    end else if (e == 11'd0) begin
      mag = 31'd0;
    end else if (eb >= 13'sd255) begin
      mag = 31'h7F800000;
    end else if (eb >= 13'sd1) begin
      q   = rne_shift({11'd0, 1'b1, m}, 6'd29);
      mag = 31'({eb[7:0] - 8'd1, 23'd0} + q[30:0]);
    end else if (eb < -13'sd32) begin
      mag = 31'd0;
    end else begin
      q   = rne_shift({11'd0, 1'b1, m}, 6'(13'sd30 - eb));
      mag = q[30:0];
    end
    return {dv[63], mag};
  endfunction

  logic [63:0] w16;
  logic [63:0] w32;
  logic [63:0] w64;
  logic [63:0] p16;
  logic [63:0] ph;
  logic [63:0] pd;
  logic [63:0] ps;

  always_comb begin
    w16 = cfg_i.swap ? swap16({48'd0, stored_word_i[15:0]}) : {48'd0, stored_word_i[15:0]};
    w32 = cfg_i.swap ? swap32({32'd0, stored_word_i[31:0]}) : {32'd0, stored_word_i[31:0]};
    w64 = cfg_i.swap ? swap64(stored_word_i) : stored_word_i;
    p16 = {48'd0, unorm_pack(float_in_i, 1'b1)};
    ph  = {48'd0, single_to_half(float_in_i)};
    ps  = {32'd0, float_in_i};
    pd  = single_to_double(float_in_i);
    float_out_o  = 32'd0;
    stored_out_o = 64'd0;
    unique case (cfg_i.fmt)
      FMT_UNORM8: begin
        if (operation_i == OP_PACK) begin
          stored_out_o = {56'd0, 8'(unorm_pack(float_in_i, 1'b0))};
        end else begin
          float_out_o = unorm_unpack({8'd0, stored_word_i[7:0]}, 1'b0);
        end
      end
      FMT_UNORM16: begin
        if (operation_i == OP_PACK) begin
          stored_out_o = cfg_i.swap ? swap16(p16) : p16;
        end else begin
          float_out_o = unorm_unpack(w16[15:0], 1'b1);
        end
      end
      FMT_HALF: begin
        if (operation_i == OP_PACK) begin
          stored_out_o = cfg_i.swap ? swap16(ph) : ph;
        end else begin
          float_out_o = half_to_single(w16[15:0]);
        end
      end
      FMT_SINGLE: begin
        if (operation_i == OP_PACK) begin
          stored_out_o = cfg_i.swap ? swap32(ps) : ps;
        end else begin
          float_out_o = w32[31:0];
        end
      end
      FMT_DOUBLE: begin
        if (operation_i == OP_PACK) begin
          stored_out_o = cfg_i.swap ? swap64(pd) : pd;
        end else begin
          float_out_o = double_to_single(w64);
        end
      end
      default: begin
        float_out_o  = 32'd0;
        stored_out_o = 64'd0;
      end
    endcase
  end

endmodule

FILE: rtl/core/pixel_format_converter_unit.sv
// Channel | Handshake                      | Payload
// in      | in_valid_i / in_ready_o        | operation_i, stored_word_i, float_in_i
// out     | out_valid_o / out_ready_i      | float_out_o, stored_out_o
// cfg     | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// One beat per cycle while no result is stalled; an accepted beat passes through the input
// register, the conversion logic and the result register before its result is valid.
// rst_ni clears the valid flags and the format/swap registers.
// A stalled result holds the result register; the input register still takes one
// beat behind it, after which in_ready_o drops until the result is taken.
module pixel_format_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [63:0] stored_word_i,
  input  logic [31:0] float_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] float_out_o,
  output logic [63:0] stored_out_o
);
  import pfc_pkg::*;

  pfc_cfg_t    cfg_q;
  logic        s1_valid_q;
  logic        s1_op_q;
  logic [63:0] s1_word_q;
  logic [31:0] s1_fin_q;
  logic        s1_adv;
  logic        out_valid_q;
  logic        out_op_q;
  logic [31:0] fout_d;
  logic [63:0] sout_d;
  logic [31:0] fout_q;
  logic [63:0] sout_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SWAP) ? {31'd0, cfg_q.swap} : {29'd0, cfg_q.fmt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FORMAT) begin
        cfg_q.fmt <= pwdata[2:0];
      end else begin
        cfg_q.swap <= pwdata[0];
      end
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q   <= operation_i;
      s1_word_q <= stored_word_i;
      s1_fin_q  <= float_in_i;
    end
  end

  pfc_convert u_convert (
    .cfg_i         (cfg_q),
    .operation_i   (s1_op_q),
    .stored_word_i (s1_word_q),
    .float_in_i    (s1_fin_q),
    .float_out_o   (fout_d),
    .stored_out_o  (sout_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fout_q   <= fout_d;
      sout_q   <= sout_d;
      out_op_q <= s1_op_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign float_out_o  = fout_q;
  assign stored_out_o = sout_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("in_ready_o low without a stalled result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_word_q) && $stable(s1_fin_q)))
    else $error("held input beat lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_op_q == OP_PACK) |-> (float_out_o == 32'd0))
    else $error("pack result with nonzero float_out_o");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_op_q == OP_UNPACK) |-> (stored_out_o == 64'd0))
    else $error("unpack result with nonzero stored_out_o");

endmodule
